// ===== rtl/core/cnm_pkg.sv =====
// Package for the CAN network-management block: codes, sizes, the per-channel
// record kept in the state memory, and the structs passed between modules.
// No dependencies.
package cnm_pkg;

    localparam int CHANNELS      = 2;
    localparam int USER_DATA_MAX = 8;
    localparam int CH_AW         = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam logic [3:0] CHAN_COUNT    = 4'(CHANNELS);
    localparam logic [2:0] CHAN_LAST     = 3'(CHANNELS - 1);
    localparam logic [3:0] USER_LEN_MAX  = 4'(USER_DATA_MAX);
    localparam logic [7:0] NM_IDLE_BYTE  = 8'hFF;

    localparam logic [15:0] TX_RELOAD_RST     = 16'd19;
    localparam logic [15:0] REPEAT_RST        = 16'd40;
    localparam logic [15:0] READY_SLEEP_RST   = 16'd100;
    localparam logic [15:0] PREPARE_SLEEP_RST = 16'd40;

    localparam logic [1:0] CFG_TX_RELOAD     = 2'd0;
    localparam logic [1:0] CFG_REPEAT        = 2'd1;
    localparam logic [1:0] CFG_READY_SLEEP   = 2'd2;
    localparam logic [1:0] CFG_PREPARE_SLEEP = 2'd3;

    typedef enum logic [2:0] {
        OP_TICK      = 3'd0,
        OP_REQUEST   = 3'd1,
        OP_RELEASE   = 3'd2,
        OP_PASSIVE   = 3'd3,
        OP_USER_DATA = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        ST_BUS_SLEEP = 3'd0,
        ST_PREPARE   = 3'd1,
        ST_READY     = 3'd2,
        ST_NORMAL    = 3'd3,
        ST_REPEAT    = 3'd4
    } nm_state_t;

    typedef enum logic [1:0] {
        MD_BUS_SLEEP = 2'd0,
        MD_PREPARE   = 2'd1,
        MD_NETWORK   = 2'd2
    } nm_mode_t;

    typedef struct packed {
        logic        requested;
        nm_state_t   st;
        nm_mode_t    md;
        logic [15:0] tx_timer;
        logic [15:0] repeat_timer;
        logic [15:0] ready_timer;
        logic [15:0] prepare_timer;
        logic [7:0]  stored_byte;
        logic [3:0]  stored_len;
    } chan_rec_t;

    localparam int REC_W = $bits(chan_rec_t);

    typedef struct packed {
        logic [15:0] tx_reload;
        logic [15:0] repeat_ticks;
        logic [15:0] ready_sleep;
        logic [15:0] prepare_sleep;
    } cfg_t;

    typedef struct packed {
        logic       changed;
        logic       start;
        logic       tx;
        logic [7:0] tx_byte;
    } upd_t;

endpackage

// ===== rtl/core/cnm_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module cnm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                                        clk,
    input  logic                                        wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                            wr_data,
    input  logic                                        rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                            rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/core/cnm_update.sv =====
// Next-state logic for one channel: applies one event to a channel record.
// Depends on cnm_pkg.
module cnm_update
    import cnm_pkg::*;
(
    input  logic [2:0] op,
    input  logic [7:0] user_byte,
    input  logic [3:0] user_len,
    input  cfg_t       cfg,
    input  chan_rec_t  rec_in,
    output chan_rec_t  rec_out,
    output upd_t       upd
);

    always_comb
    begin
        chan_rec_t  r;
        logic       start;
        logic       tx;
        logic [7:0] tx_byte;
        logic [7:0] nm_byte;

        r       = rec_in;
        start   = 1'b0;
        tx      = 1'b0;
        tx_byte = 8'd0;
        nm_byte = (rec_in.stored_len != 4'd0) ? rec_in.stored_byte : NM_IDLE_BYTE;

        unique case (op)
            OP_TICK:
            begin
                if (rec_in.requested)
                begin
                    if (rec_in.st == ST_BUS_SLEEP || (rec_in.st != ST_REPEAT &&
                                                      rec_in.md != MD_NETWORK))
                    begin
                        r.ready_timer   = 16'd0;
                        r.prepare_timer = 16'd0;
                        r.repeat_timer  = cfg.repeat_ticks;
                        r.st            = ST_REPEAT;
                        r.md            = MD_NETWORK;
                    end
                    else if (rec_in.st == ST_REPEAT)
                    begin
                        if (rec_in.repeat_timer != 16'd0)
                        begin
                            r.repeat_timer = rec_in.repeat_timer - 16'd1;
                        end
                        else
                        begin
                            r.st = ST_NORMAL;
                            r.md = MD_NETWORK;
                        end
                    end
                    if (rec_in.tx_timer != 16'd0)
                    begin
                        r.tx_timer = rec_in.tx_timer - 16'd1;
                    end
                    else
                    begin
                        tx         = 1'b1;
                        tx_byte    = nm_byte;
                        r.tx_timer = cfg.tx_reload;
                    end
                end
                else if (rec_in.st == ST_NORMAL || rec_in.st == ST_REPEAT)
                begin
                    r.ready_timer = cfg.ready_sleep;
                    r.st          = ST_READY;
                    r.md          = MD_NETWORK;
                end
                else if (rec_in.st == ST_READY)
                begin
                    if (rec_in.ready_timer != 16'd0)
                    begin
                        r.ready_timer = rec_in.ready_timer - 16'd1;
                    end
                    else
                    begin
                        r.prepare_timer = cfg.prepare_sleep;
                        r.st            = ST_PREPARE;
                        r.md            = MD_PREPARE;
                    end
                end
                else if (rec_in.st == ST_PREPARE)
                begin
                    if (rec_in.prepare_timer != 16'd0)
                    begin
                        r.prepare_timer = rec_in.prepare_timer - 16'd1;
                    end
                    else
                    begin
                        r.st = ST_BUS_SLEEP;
                        r.md = MD_BUS_SLEEP;
                    end
                end
            end
            OP_REQUEST:
            begin
                r.requested     = 1'b1;
                r.tx_timer      = 16'd0;
                r.ready_timer   = 16'd0;
                r.prepare_timer = 16'd0;
                r.repeat_timer  = cfg.repeat_ticks;
                r.st            = ST_REPEAT;
                r.md            = MD_NETWORK;
                tx              = 1'b1;
                tx_byte         = nm_byte;
            end
            OP_RELEASE:
            begin
                r.requested = 1'b0;
                tx          = 1'b1;
                if (rec_in.md == MD_NETWORK)
                begin
                    r.ready_timer = cfg.ready_sleep;
                    r.st          = ST_READY;
                    r.md          = MD_NETWORK;
                end
            end
            OP_PASSIVE:
            begin
                start           = 1'b1;
                r.ready_timer   = 16'd0;
                r.prepare_timer = 16'd0;
                r.repeat_timer  = cfg.repeat_ticks;
                r.st            = ST_REPEAT;
                r.md            = MD_NETWORK;
            end
            default:
            begin
                if (user_len != 4'd0)
                begin
                    r.stored_byte = user_byte;
                end
                r.stored_len = user_len;
                if (rec_in.requested)
                begin
                    tx      = 1'b1;
                    tx_byte = (user_len != 4'd0) ? user_byte : NM_IDLE_BYTE;
                end
            end
        endcase

        rec_out     = r;
        upd.changed = (r.st != rec_in.st) || (r.md != rec_in.md);
        upd.start   = start;
        upd.tx      = tx;
        upd.tx_byte = tx_byte;
    end

endmodule

// ===== rtl/core/can_network_management_fsm.sv =====
// Top level of the CAN network-management block: handshakes, configuration
// registers, the per-channel state memory and the sequencer around it.
// Depends on cnm_pkg, cnm_ram and cnm_update.
//
// Every channel's state lives in one record of a small memory and is updated
// by read, modify and write back. A request, release, passive startup or
// set-user-data transaction gives its single result after its record is read,
// updated and the result registered; a rejected transaction (bad op, channel
// or length) gives its error result in the cycle after acceptance. A tick
// gives one result per channel, in channel order; the next channel's record
// is read only once the previous result is taken. in_ready returns in the
// cycle after the last result of the current input is taken. Valid bits make
// every channel read as bus sleep with cleared timers after reset, so no
// clearing pass is needed. Configuration writes are taken at any time.
module can_network_management_fsm
    import cnm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  op,
    input  logic [2:0]  chan,
    input  logic [7:0]  user_byte,
    input  logic [3:0]  user_len,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  chan_out,
    output logic        status,
    output logic [2:0]  nm_state,
    output logic [1:0]  nm_mode,
    output logic        mode_indication,
    output logic        start_indication,
    output logic        tx_valid,
    output logic [7:0]  tx_byte,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CALC = 3'b010,
        S_OUT  = 3'b100
    } seq_state_t;

    seq_state_t          state_reg, state_next;
    cfg_t                cfg_reg;
    logic [CHANNELS-1:0] valid_reg, valid_next;
    logic [2:0]          cnt_reg, cnt_next;
    logic [2:0]          op_reg, op_next;
    logic [7:0]          ubyte_reg, ubyte_next;
    logic [3:0]          ulen_reg, ulen_next;

    logic [2:0]  chan_out_reg, chan_out_next;
    logic        status_reg, status_next;
    logic [2:0]  nm_state_reg, nm_state_next;
    logic [1:0]  nm_mode_reg, nm_mode_next;
    logic        mode_ind_reg, mode_ind_next;
    logic        start_ind_reg, start_ind_next;
    logic        tx_valid_reg, tx_valid_next;
    logic [7:0]  tx_byte_reg, tx_byte_next;
    logic        last_reg, last_next;

    logic             rd_en;
    logic [CH_AW-1:0] rd_addr;
    logic             wr_en;
    logic [REC_W-1:0] rd_data;
    chan_rec_t        rec_in;
    chan_rec_t        rec_out;
    upd_t             upd;
    logic             in_err;
    logic [2:0]       first_chan;
    logic [2:0]       cnt_inc;

    cnm_ram #(
        .WIDTH(REC_W),
        .DEPTH(CHANNELS)
    ) u_state_ram (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(cnt_reg[CH_AW-1:0]),
        .wr_data(REC_W'(rec_out)),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    assign rec_in = valid_reg[cnt_reg[CH_AW-1:0]] ? chan_rec_t'(rd_data) : chan_rec_t'('0);

    cnm_update u_update (
        .op       (op_reg),
        .user_byte(ubyte_reg),
        .user_len (ulen_reg),
        .cfg      (cfg_reg),
        .rec_in   (rec_in),
        .rec_out  (rec_out),
        .upd      (upd)
    );

    assign in_err = (op > OP_USER_DATA) ||
                    (op != OP_TICK && {1'b0, chan} >= CHAN_COUNT) ||
                    (op == OP_USER_DATA && user_len > USER_LEN_MAX);
    assign first_chan = (op == OP_TICK) ? 3'd0 : chan;
    assign cnt_inc    = cnt_reg + 3'd1;

    always_comb
    begin
        state_next     = state_reg;
        valid_next     = valid_reg;
        cnt_next       = cnt_reg;
        op_next        = op_reg;
        ubyte_next     = ubyte_reg;
        ulen_next      = ulen_reg;
        chan_out_next  = chan_out_reg;
        status_next    = status_reg;
        nm_state_next  = nm_state_reg;
        nm_mode_next   = nm_mode_reg;
        mode_ind_next  = mode_ind_reg;
        start_ind_next = start_ind_reg;
        tx_valid_next  = tx_valid_reg;
        tx_byte_next   = tx_byte_reg;
        last_next      = last_reg;
        rd_en          = 1'b0;
        rd_addr        = cnt_reg[CH_AW-1:0];
        wr_en          = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = op;
                    ubyte_next = user_byte;
                    ulen_next  = user_len;
                    if (in_err)
                    begin
                        chan_out_next  = chan;
                        status_next    = 1'b1;
                        nm_state_next  = 3'd0;
                        nm_mode_next   = 2'd0;
                        mode_ind_next  = 1'b0;
                        start_ind_next = 1'b0;
                        tx_valid_next  = 1'b0;
                        tx_byte_next   = 8'd0;
                        last_next      = 1'b1;
                        state_next     = S_OUT;
                    end
                    else
                    begin
                        cnt_next   = first_chan;
                        rd_en      = 1'b1;
                        rd_addr    = first_chan[CH_AW-1:0];
                        state_next = S_CALC;
                    end
                end
            end
            S_CALC:
            begin
                wr_en                          = 1'b1;
                valid_next[cnt_reg[CH_AW-1:0]] = 1'b1;
                chan_out_next  = cnt_reg;
                status_next    = 1'b0;
                nm_state_next  = rec_out.st;
                nm_mode_next   = rec_out.md;
                mode_ind_next  = upd.changed;
                start_ind_next = upd.start;
                tx_valid_next  = upd.tx;
                tx_byte_next   = upd.tx_byte;
                last_next      = (op_reg != OP_TICK) || (cnt_reg == CHAN_LAST);
                state_next     = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    if (!last_reg)
                    begin
                        cnt_next   = cnt_inc;
                        rd_en      = 1'b1;
                        rd_addr    = cnt_inc[CH_AW-1:0];
                        state_next = S_CALC;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
            cnt_reg   <= 3'd0;
            op_reg    <= 3'd0;
            last_reg  <= 1'b0;
            cfg_reg.tx_reload     <= TX_RELOAD_RST;
            cfg_reg.repeat_ticks  <= REPEAT_RST;
            cfg_reg.ready_sleep   <= READY_SLEEP_RST;
            cfg_reg.prepare_sleep <= PREPARE_SLEEP_RST;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            cnt_reg   <= cnt_next;
            op_reg    <= op_next;
            last_reg  <= last_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_TX_RELOAD:     cfg_reg.tx_reload     <= cfg_data;
                    CFG_REPEAT:        cfg_reg.repeat_ticks  <= cfg_data;
                    CFG_READY_SLEEP:   cfg_reg.ready_sleep   <= cfg_data;
                    CFG_PREPARE_SLEEP: cfg_reg.prepare_sleep <= cfg_data;
                    default:           cfg_reg.tx_reload     <= cfg_reg.tx_reload;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ubyte_reg     <= ubyte_next;
        ulen_reg      <= ulen_next;
        chan_out_reg  <= chan_out_next;
        status_reg    <= status_next;
        nm_state_reg  <= nm_state_next;
        nm_mode_reg   <= nm_mode_next;
        mode_ind_reg  <= mode_ind_next;
        start_ind_reg <= start_ind_next;
        tx_valid_reg  <= tx_valid_next;
        tx_byte_reg   <= tx_byte_next;
    end

    assign in_ready         = (state_reg == S_IDLE);
    assign out_valid        = (state_reg == S_OUT);
    assign cfg_ready        = 1'b1;
    assign chan_out         = chan_out_reg;
    assign status           = status_reg;
    assign nm_state         = nm_state_reg;
    assign nm_mode          = nm_mode_reg;
    assign mode_indication  = mode_ind_reg;
    assign start_indication = start_ind_reg;
    assign tx_valid         = tx_valid_reg;
    assign tx_byte          = tx_byte_reg;
    assign last             = last_reg;

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for can_network_management_fsm: drives NM events and
// timer settings, predicts every per-channel result and checks it field by field.
// Depends on cnm_pkg and the RTL of the block.
module testbench
    import cnm_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          IDLE_PCT       = 19;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          SETTLE_CYCLES  = 4;
    localparam logic [2:0]  OP_BAD_FIRST   = 3'd5;
    localparam logic [2:0]  OP_BAD_LAST    = 3'd7;
    localparam int          NUM_FIELDS     = 9;

    typedef struct packed {
        logic [2:0] op;
        logic [2:0] chan;
        logic [7:0] ubyte;
        logic [3:0] ulen;
    } nm_event_t;

    typedef struct packed {
        logic [2:0] chan;
        logic       status;
        nm_state_t  st;
        nm_mode_t   md;
        logic       mode_ind;
        logic       start_ind;
        logic       tx_v;
        logic [7:0] tx_b;
        logic       last_f;
    } nm_result_t;

    typedef struct {
        logic        requested;
        nm_state_t   st;
        nm_mode_t    md;
        logic [15:0] tx_cnt;
        logic [15:0] repeat_cnt;
        logic [15:0] ready_cnt;
        logic [15:0] prepare_cnt;
        logic [7:0]  ubyte;
        logic [3:0]  ulen;
    } nm_channel_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [2:0]  op = '0;
    logic [2:0]  chan = '0;
    logic [7:0]  user_byte = '0;
    logic [3:0]  user_len = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  chan_out;
    logic        status;
    logic [2:0]  nm_state;
    logic [1:0]  nm_mode;
    logic        mode_indication;
    logic        start_indication;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        last;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    can_network_management_fsm dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .op               (op),
        .chan             (chan),
        .user_byte        (user_byte),
        .user_len         (user_len),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .chan_out         (chan_out),
        .status           (status),
        .nm_state         (nm_state),
        .nm_mode          (nm_mode),
        .mode_indication  (mode_indication),
        .start_indication (start_indication),
        .tx_valid         (tx_valid),
        .tx_byte          (tx_byte),
        .last             (last),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    nm_event_t   pending_events[$];
    nm_result_t  expected_results[$];
    nm_channel_t channels[CHANNELS];

    logic [15:0] tx_reload_ticks;
    logic [15:0] repeat_ticks;
    logic [15:0] ready_sleep_ticks;
    logic [15:0] prepare_sleep_ticks;

    logic        state_changed;
    logic        nm_sent;
    logic [7:0]  nm_byte;

    logic        in_taken = 1'b0;
    logic        cfg_taken = 1'b0;
    logic        gaps_on = 1'b1;
    int          events_queued = 0;
    int          events_taken = 0;
    int          results_checked = 0;
    int          nm_bytes_seen = 0;
    int          error_results = 0;
    int          cfg_writes = 0;
    int          mismatches = 0;
    int          quiet_cycles = 0;

    string field_names[NUM_FIELDS] = '{"chan_out", "status", "nm_state", "nm_mode",
        "mode_indication", "start_indication", "tx_valid", "tx_byte", "last"};

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic void move_to(int c, nm_state_t s, nm_mode_t m);
        if (channels[c].st != s || channels[c].md != m)
        begin
            channels[c].st = s;
            channels[c].md = m;
            state_changed  = 1'b1;
        end
    endfunction

    function automatic void join_network(int c);
        channels[c].ready_cnt   = '0;
        channels[c].prepare_cnt = '0;
        channels[c].repeat_cnt  = repeat_ticks;
        move_to(c, ST_REPEAT, MD_NETWORK);
    endfunction

    function automatic void send_nm_byte(int c);
        nm_sent = 1'b1;
        nm_byte = (channels[c].ulen != 0) ? channels[c].ubyte : NM_IDLE_BYTE;
    endfunction

    function automatic void requested_tick(int c);
        if (channels[c].st == ST_BUS_SLEEP)
            join_network(c);
        else if (channels[c].st == ST_REPEAT)
        begin
            if (channels[c].repeat_cnt > 0)
                channels[c].repeat_cnt--;
            else
                move_to(c, ST_NORMAL, MD_NETWORK);
        end
        else if (channels[c].md != MD_NETWORK)
            join_network(c);
        if (channels[c].tx_cnt > 0)
            channels[c].tx_cnt--;
        else
        begin
            send_nm_byte(c);
            channels[c].tx_cnt = tx_reload_ticks;
        end
    endfunction

    function automatic void released_tick(int c);
        case (channels[c].st)
            ST_NORMAL, ST_REPEAT:
            begin
                channels[c].ready_cnt = ready_sleep_ticks;
                move_to(c, ST_READY, MD_NETWORK);
            end
            ST_READY:
            begin
                if (channels[c].ready_cnt > 0)
                    channels[c].ready_cnt--;
                else
                begin
                    channels[c].prepare_cnt = prepare_sleep_ticks;
                    move_to(c, ST_PREPARE, MD_PREPARE);
                end
            end
            ST_PREPARE:
            begin
                if (channels[c].prepare_cnt > 0)
                    channels[c].prepare_cnt--;
                else
                    move_to(c, ST_BUS_SLEEP, MD_BUS_SLEEP);
            end
            default: ;
        endcase
    endfunction

    function automatic void push_channel_result(int c, logic start, logic is_last);
        nm_result_t r;
        r.chan      = 3'(c);
        r.status    = 1'b0;
        r.st        = channels[c].st;
        r.md        = channels[c].md;
        r.mode_ind  = state_changed;
        r.start_ind = start;
        r.tx_v      = nm_sent;
        r.tx_b      = nm_sent ? nm_byte : 8'h00;
        r.last_f    = is_last;
        expected_results.push_back(r);
    endfunction

    function automatic void predict_event(nm_event_t e);
        nm_result_t r;
        int         c;
        logic       start;
        start         = 1'b0;
        state_changed = 1'b0;
        nm_sent       = 1'b0;
        nm_byte       = 8'h00;
        if (e.op == OP_TICK)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                state_changed = 1'b0;
                nm_sent       = 1'b0;
                nm_byte       = 8'h00;
                if (channels[i].requested)
                    requested_tick(i);
                else
                    released_tick(i);
                push_channel_result(i, 1'b0, i == CHANNELS - 1);
            end
            return;
        end
        if (e.op > OP_USER_DATA || int'(e.chan) >= CHANNELS ||
            (e.op == OP_USER_DATA && e.ulen > USER_LEN_MAX))
        begin
            r        = '0;
            r.chan   = e.chan;
            r.status = 1'b1;
            r.st     = ST_BUS_SLEEP;
            r.md     = MD_BUS_SLEEP;
            r.last_f = 1'b1;
            expected_results.push_back(r);
            return;
        end
        c = int'(e.chan);
        case (e.op)
            OP_REQUEST:
            begin
                channels[c].requested = 1'b1;
                channels[c].tx_cnt    = '0;
                join_network(c);
                send_nm_byte(c);
            end
            OP_RELEASE:
            begin
                channels[c].requested = 1'b0;
                nm_sent = 1'b1;
                nm_byte = 8'h00;
                if (channels[c].md == MD_NETWORK)
                begin
                    channels[c].ready_cnt = ready_sleep_ticks;
                    move_to(c, ST_READY, MD_NETWORK);
                end
            end
            OP_PASSIVE:
            begin
                start = 1'b1;
                join_network(c);
            end
            default:
            begin
                if (e.ulen != 0)
                    channels[c].ubyte = e.ubyte;
                channels[c].ulen = e.ulen;
                if (channels[c].requested)
                    send_nm_byte(c);
            end
        endcase
        push_channel_result(c, start, 1'b1);
    endfunction

    function automatic void split_fields(nm_result_t r, output int f[NUM_FIELDS]);
        f = '{int'(r.chan), int'(r.status), int'(r.st), int'(r.md), int'(r.mode_ind),
              int'(r.start_ind), int'(r.tx_v), int'(r.tx_b), int'(r.last_f)};
    endfunction

    task automatic report_mismatch(string msg);
        mismatches++;
        $display("ERROR at %0t: %s", $realtime, msg);
    endtask

    task automatic check_result(nm_result_t got);
        nm_result_t want;
        int         got_f[NUM_FIELDS];
        int         want_f[NUM_FIELDS];
        if (expected_results.size() == 0)
        begin
            report_mismatch($sformatf("result for channel %0d arrived with none expected",
                                      got.chan));
            return;
        end
        want = expected_results.pop_front();
        if (want.tx_v)
            nm_bytes_seen++;
        if (want.status)
            error_results++;
        split_fields(got, got_f);
        split_fields(want, want_f);
        for (int i = 0; i < NUM_FIELDS; i++)
            if (got_f[i] != want_f[i])
                report_mismatch($sformatf("result %0d field %s: got %0d, expected %0d",
                                          results_checked, field_names[i], got_f[i],
                                          want_f[i]));
        results_checked++;
    endtask

    always @(posedge clk)
    begin
        nm_result_t got;
        logic       any_taken;
        any_taken = 1'b0;
        in_taken  = rst_n && in_valid && in_ready;
        cfg_taken = rst_n && cfg_valid && cfg_ready;
        if (rst_n && out_valid && out_ready)
        begin
            got.chan      = chan_out;
            got.status    = status;
            got.st        = nm_state_t'(nm_state);
            got.md        = nm_mode_t'(nm_mode);
            got.mode_ind  = mode_indication;
            got.start_ind = start_indication;
            got.tx_v      = tx_valid;
            got.tx_b      = tx_byte;
            got.last_f    = last;
            check_result(got);
            any_taken = 1'b1;
        end
        if (in_taken)
        begin
            predict_event('{op: op, chan: chan, ubyte: user_byte, ulen: user_len});
            events_taken++;
            any_taken = 1'b1;
        end
        if (cfg_taken)
        begin
            case (cfg_index)
                CFG_TX_RELOAD:     tx_reload_ticks     = cfg_data;
                CFG_REPEAT:        repeat_ticks        = cfg_data;
                CFG_READY_SLEEP:   ready_sleep_ticks   = cfg_data;
                CFG_PREPARE_SLEEP: prepare_sleep_ticks = cfg_data;
                default: ;
            endcase
            cfg_writes++;
            any_taken = 1'b1;
        end
        quiet_cycles = any_taken ? 0 : quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        nm_event_t e;
        if (!in_valid || in_taken)
        begin
            if (gaps_on && $urandom_range(99) < IDLE_PCT)
                in_valid <= 1'b0;
            else if (pending_events.size() > 0)
            begin
                e = pending_events.pop_front();
                op        <= e.op;
                chan      <= e.chan;
                user_byte <= e.ubyte;
                user_len  <= e.ulen;
                in_valid  <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
        out_ready <= !(gaps_on && $urandom_range(99) < IDLE_PCT);
    end

    task automatic add_event(input logic [2:0] o, input logic [2:0] ch,
                             input logic [7:0] b, input logic [3:0] l);
        pending_events.push_back('{op: o, chan: ch, ubyte: b, ulen: l});
        events_queued++;
    endtask

    function automatic nm_event_t random_event();
        nm_event_t e;
        int        pick;
        int        kind;
        pick    = $urandom_range(99);
        e.ubyte = 8'($urandom_range(255));
        e.chan  = 3'($urandom_range(CHANNELS - 1));
        e.ulen  = 4'($urandom_range(USER_DATA_MAX));
        if (pick < 85)
        begin
            kind = $urandom_range(99);
            if (kind < 50)
            begin
                e.op   = OP_TICK;
                e.chan = 3'($urandom_range(7));
                e.ulen = 4'($urandom_range(15));
            end
            else if (kind < 62)
                e.op = OP_REQUEST;
            else if (kind < 74)
                e.op = OP_RELEASE;
            else if (kind < 82)
                e.op = OP_PASSIVE;
            else
                e.op = OP_USER_DATA;
        end
        else if (pick < 90)
        begin
            e.op   = 3'($urandom_range(OP_REQUEST, OP_USER_DATA));
            e.chan = 3'($urandom_range(CHANNELS, 7));
        end
        else if (pick < 95)
        begin
            e.op   = 3'($urandom_range(OP_BAD_FIRST, OP_BAD_LAST));
            e.chan = 3'($urandom_range(7));
            e.ulen = 4'($urandom_range(15));
        end
        else
        begin
            e.op   = OP_USER_DATA;
            e.ulen = 4'($urandom_range(USER_DATA_MAX + 1, 15));
        end
        return e;
    endfunction

    task automatic wait_idle();
        do
            @(negedge clk);
        while (events_taken != events_queued || expected_results.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(negedge clk);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do
            @(negedge clk);
        while (!cfg_taken);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_timers(input logic [15:0] tx, input logic [15:0] rep,
                              input logic [15:0] rdy, input logic [15:0] prep);
        write_reg(CFG_TX_RELOAD, tx);
        write_reg(CFG_REPEAT, rep);
        write_reg(CFG_READY_SLEEP, rdy);
        write_reg(CFG_PREPARE_SLEEP, prep);
    endtask

    task automatic run_phase(int count);
        nm_event_t e;
        for (int i = 0; i < count; i++)
        begin
            e = random_event();
            add_event(e.op, e.chan, e.ubyte, e.ulen);
        end
        wait_idle();
    endtask

    initial
    begin
        tx_reload_ticks     = TX_RELOAD_RST;
        repeat_ticks        = REPEAT_RST;
        ready_sleep_ticks   = READY_SLEEP_RST;
        prepare_sleep_ticks = PREPARE_SLEEP_RST;
        for (int i = 0; i < CHANNELS; i++)
            channels[i] = '{requested: 1'b0, st: ST_BUS_SLEEP, md: MD_BUS_SLEEP,
                            tx_cnt: '0, repeat_cnt: '0, ready_cnt: '0, prepare_cnt: '0,
                            ubyte: '0, ulen: '0};
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        add_event(OP_RELEASE, 3'd1, 8'h00, 4'd0);
        add_event(OP_USER_DATA, 3'd0, 8'hA5, 4'd0);
        add_event(OP_REQUEST, 3'd0, 8'h00, 4'd0);
        add_event(OP_USER_DATA, 3'd0, 8'hFF, USER_LEN_MAX);
        add_event(OP_USER_DATA, 3'd0, 8'h00, 4'd1);
        add_event(OP_USER_DATA, 3'd1, 8'h3C, USER_LEN_MAX + 4'd1);
        add_event(OP_USER_DATA, 3'd1, 8'hC3, 4'd15);
        add_event(OP_PASSIVE, 3'd1, 8'h00, 4'd0);
        add_event(OP_PASSIVE, 3'd0, 8'h00, 4'd0);
        add_event(OP_TICK, 3'd7, 8'hFF, 4'd15);
        add_event(OP_TICK, 3'd0, 8'h00, 4'd0);
        add_event(OP_REQUEST, 3'd1, 8'h00, 4'd0);
        add_event(OP_USER_DATA, 3'd1, 8'h5A, 4'd3);
        add_event(OP_TICK, 3'd0, 8'h00, 4'd0);
        add_event(OP_RELEASE, 3'd0, 8'h00, 4'd0);
        add_event(OP_RELEASE, 3'd1, 8'h00, 4'd0);
        add_event(OP_TICK, 3'd0, 8'h00, 4'd0);
        add_event(OP_REQUEST, CHAN_LAST + 3'd1, 8'h00, 4'd0);
        add_event(OP_PASSIVE, 3'd7, 8'hFF, 4'd0);
        add_event(OP_BAD_FIRST, 3'd0, 8'h00, 4'd0);
        add_event(OP_BAD_FIRST + 3'd1, 3'd1, 8'h81, 4'd2);
        add_event(OP_BAD_LAST, 3'd7, 8'hFF, 4'd15);
        add_event(OP_USER_DATA, 3'd0, 8'h00, 4'd0);
        add_event(OP_TICK, 3'd0, 8'h00, 4'd0);
        wait_idle();

        set_timers(16'd0, 16'd0, 16'd0, 16'd0);
        run_phase(65);
        set_timers(16'd2, 16'd5, 16'd4, 16'd3);
        run_phase(65);
        set_timers(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_phase(40);
        set_timers(16'd1, 16'd3, 16'd0, 16'hFFFF);
        run_phase(50);
        set_timers(16'($urandom_range(6)), 16'($urandom_range(6)),
                   16'($urandom_range(6)), 16'($urandom_range(6)));
        run_phase(70);
        gaps_on = 1'b0;
        set_timers(16'd3, 16'd8, 16'd12, 16'd6);
        run_phase(90);
        gaps_on = 1'b1;
        set_timers(TX_RELOAD_RST, REPEAT_RST, READY_SLEEP_RST, PREPARE_SLEEP_RST);
        run_phase(75);

        $display("Covered %0d input transactions and %0d register writes; %0d results checked.",
                 events_taken, cfg_writes, results_checked);
        $display("Results carried %0d NM bytes and %0d error reports; %0d mismatches.",
                 nm_bytes_seen, error_results, mismatches);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== can_network_management_fsm.f =====
rtl/core/cnm_pkg.sv
rtl/core/cnm_ram.sv
rtl/core/cnm_update.sv
rtl/core/can_network_management_fsm.sv
dv/testbench.sv
